>>> sv/huffman_tree_decoder_unit_assert.svh
// Assertion macros shared by the Huffman tree decoder RTL.
`ifndef HUFFMAN_TREE_DECODER_UNIT_ASSERT_SVH
`define HUFFMAN_TREE_DECODER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define HTDU_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);
`define HTDU_ASSERT_NEXT(lbl, ck, rs, pre, post, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) pre |=> post) else $error(msg);
`else
`define HTDU_ASSERT(lbl, ck, rs, prop, msg)
`define HTDU_ASSERT_NEXT(lbl, ck, rs, pre, post, msg)
`endif
`endif

>>> sv/htd_pkg.sv
// Constants and codes for the Huffman tree decoder.
`timescale 1ns / 1ps
`default_nettype none
package htd_pkg;
  localparam int NODES_DEF        = 512;
  localparam int MAX_CODE_LEN_DEF = 32;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  localparam logic [1:0] ST_SYMBOL = 2'd0;
  localparam logic [1:0] ST_LOADED = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_BAD    = 2'd3;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
endpackage
`default_nettype wire

>>> sv/huffman_tree_decoder_unit.sv
// Huffman tree decoder: node table in block memory, load and decode sequencer.
//
// A request is taken when start is high and busy is low. A load request
// (command 0) walks the code in bits from the root, most significant used
// bit first, and allocates missing nodes; it gives one result: code loaded
// or table full. A decode request (command 1) walks the tree one bit at a
// time from the node left by the previous segment and gives one symbol per
// leaf reached (a percent sign comes out as a newline) and one bad-code
// result per missing child. The final result of a request has last set.
// Each result is on the outputs for one cycle, marked by strobe; the
// receiver cannot stall the block and need not.
// Every table step is one read of the link memory. A load takes a step per
// bit until the code ends or the table is full, clears the links of a node
// that the last bit allocated, and finishes; a decode takes a child step
// per bit, a leaf check for each child found, and a finish step. A result
// is held until the next one is found or the request ends, so that last
// can be marked; the final result is on the outputs once busy falls.
// Reset empties the tree and returns the walk to the root.
`timescale 1ns / 1ps
`default_nettype none
`include "huffman_tree_decoder_unit_assert.svh"
module huffman_tree_decoder_unit #(
  parameter int NODES        = htd_pkg::NODES_DEF,
  parameter int MAX_CODE_LEN = htd_pkg::MAX_CODE_LEN_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        command,
  input  wire logic [31:0] bits,
  input  wire logic [5:0]  bit_count,
  input  wire logic [7:0]  symbol_in,
  output logic             strobe,
  output logic [7:0]       symbol_out,
  output logic [1:0]       status,
  output logic             last
);
  localparam int IW  = $clog2(NODES);
  localparam int NFW = $clog2(NODES + 1);
  localparam logic [5:0] CNT_LIM = 6'(MAX_CODE_LEN < 32 ? MAX_CODE_LEN : 32);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LSTEP = 3'd1;
  localparam logic [2:0] S_LZERO = 3'd2;
  localparam logic [2:0] S_DSTEP = 3'd3;
  localparam logic [2:0] S_DLEAF = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2*IW-1:0] links [NODES];
  logic [7:0]      syms  [NODES];

  logic [2:0]      state;
  logic [NFW-1:0]  nf;
  logic [IW-1:0]   cur;
  logic [IW-1:0]   node;
  logic            fresh;
  logic [5:0]      rem;
  logic [31:0]     bits_q;
  logic [7:0]      sym_q;
  logic [IW-1:0]   root_left;
  logic [IW-1:0]   root_right;
  logic            pend_valid;
  logic [7:0]      pend_sym;
  logic [1:0]      pend_st;

  logic [2*IW-1:0] rd_link;
  logic [7:0]      rd_sym;
  logic            rd_root;

  logic [5:0]      cnt_n;
  logic [5:0]      rem_m1;
  logic            b;
  logic            last_bit;
  logic [IW-1:0]   data_l;
  logic [IW-1:0]   data_r;
  logic [IW-1:0]   ld_l;
  logic [IW-1:0]   ld_r;
  logic [IW-1:0]   slot;
  logic [IW-1:0]   dchild;
  logic [IW-1:0]   alloc_ptr;
  logic [IW-1:0]   new_l;
  logic [IW-1:0]   new_r;
  logic            is_full;
  logic            leaf;
  logic [IW-1:0]   rd_addr;
  logic            link_we;
  logic [2*IW-1:0] link_wd;
  logic            root_we;
  logic            sym_we;
  logic            push_en;
  logic [1:0]      push_st;
  logic [7:0]      push_sym;

  assign busy      = (state != S_IDLE);
  assign cnt_n     = (bit_count > CNT_LIM) ? CNT_LIM : bit_count;
  assign rem_m1    = rem - 6'd1;
  assign b         = bits_q[rem_m1[4:0]];
  assign last_bit  = (rem == 6'd1);
  assign data_l    = rd_root ? root_left : rd_link[IW-1:0];
  assign data_r    = rd_root ? root_right : rd_link[2*IW-1:IW];
  assign ld_l      = fresh ? '0 : data_l;
  assign ld_r      = fresh ? '0 : data_r;
  assign slot      = b ? ld_r : ld_l;
  assign dchild    = b ? data_r : data_l;
  assign is_full   = (nf >= NFW'(NODES));
  assign alloc_ptr = IW'(nf);
  assign new_l     = b ? ld_l : alloc_ptr;
  assign new_r     = b ? alloc_ptr : ld_r;
  assign leaf      = (data_l == '0) && (data_r == '0);

  always_comb begin
    rd_addr  = node;
    link_we  = 1'b0;
    link_wd  = {new_r, new_l};
    root_we  = 1'b0;
    sym_we   = 1'b0;
    push_en  = 1'b0;
    push_st  = htd_pkg::ST_LOADED;
    push_sym = 8'd0;
    unique case (state)
      S_IDLE: begin
        rd_addr = (command == htd_pkg::CMD_LOAD) ? '0 : cur;
        push_en = start && (command == htd_pkg::CMD_LOAD) && (cnt_n == 6'd0);
      end
      S_LSTEP: begin
        rd_addr = slot;
        if (slot != '0) begin
          push_en = last_bit;
        end else if (is_full) begin
          push_en = 1'b1;
          push_st = htd_pkg::ST_FULL;
          link_we = fresh;
          link_wd = '0;
        end else begin
          root_we = (node == '0);
          link_we = (node != '0);
          sym_we  = 1'b1;
          push_en = last_bit;
        end
      end
      S_LZERO: begin
        link_we = 1'b1;
        link_wd = '0;
      end
      S_DSTEP: begin
        rd_addr = dchild;
        push_en = (dchild == '0);
        push_st = htd_pkg::ST_BAD;
      end
      S_DLEAF: begin
        rd_addr  = leaf ? '0 : node;
        push_en  = leaf;
        push_st  = htd_pkg::ST_SYMBOL;
        push_sym = (rd_sym == htd_pkg::CH_PERCENT) ? htd_pkg::CH_NEWLINE : rd_sym;
      end
      S_FIN: begin
        rd_addr = '0;
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      links[node] <= link_wd;
    end
    if (sym_we) begin
      syms[alloc_ptr] <= sym_q;
    end
    rd_link <= links[rd_addr];
    rd_sym  <= syms[rd_addr];
    rd_root <= (rd_addr == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      nf         <= NFW'(1);
      cur        <= '0;
      root_left  <= '0;
      root_right <= '0;
      pend_valid <= 1'b0;
      strobe     <= 1'b0;
      last       <= 1'b0;
    end else begin
      strobe <= pend_valid && ((state == S_FIN) || push_en);
      if (root_we) begin
        root_left  <= new_l;
        root_right <= new_r;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            bits_q <= bits;
            sym_q  <= symbol_in;
            rem    <= cnt_n;
            node   <= '0;
            fresh  <= 1'b0;
            if (cnt_n == 6'd0) begin
              state <= S_FIN;
            end else if (command == htd_pkg::CMD_LOAD) begin
              state <= S_LSTEP;
            end else begin
              state <= S_DSTEP;
            end
          end
        end
        S_LSTEP: begin
          if (slot != '0) begin
            node  <= slot;
            fresh <= 1'b0;
            rem   <= rem_m1;
            if (last_bit) begin
              state <= S_FIN;
            end
          end else if (is_full) begin
            state <= S_FIN;
          end else begin
            node  <= alloc_ptr;
            nf    <= nf + NFW'(1);
            fresh <= 1'b1;
            rem   <= rem_m1;
            if (last_bit) begin
              state <= S_LZERO;
            end
          end
        end
        S_LZERO: begin
          state <= S_FIN;
        end
        S_DSTEP: begin
          rem <= rem_m1;
          if (dchild == '0) begin
            cur <= '0;
            if (last_bit) begin
              state <= S_FIN;
            end
          end else begin
            node  <= dchild;
            state <= S_DLEAF;
          end
        end
        S_DLEAF: begin
          cur   <= leaf ? '0 : node;
          state <= (rem == 6'd0) ? S_FIN : S_DSTEP;
        end
        S_FIN: begin
          if (pend_valid) begin
            symbol_out <= pend_sym;
            status     <= pend_st;
            last       <= 1'b1;
            pend_valid <= 1'b0;
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (push_en) begin
        if (pend_valid) begin
          symbol_out <= pend_sym;
          status     <= pend_st;
          last       <= 1'b0;
        end
        pend_valid <= 1'b1;
        pend_sym   <= push_sym;
        pend_st    <= push_st;
      end
    end
  end

  `HTDU_ASSERT(a_strobe_from_work, clk, rst, strobe |-> $past(state != S_IDLE), "result without request")
  `HTDU_ASSERT_NEXT(a_nf_grows, clk, rst, 1'b1, nf >= $past(nf), "free pointer went back")
  `HTDU_ASSERT(a_write_allocated, clk, rst, link_we |-> (node != '0) && (NFW'(node) < nf), "write to free node")
  `HTDU_ASSERT_NEXT(a_fin_flushes, clk, rst, state == S_FIN, !pend_valid && (state == S_IDLE), "result left pending")
  `HTDU_ASSERT(a_leaf_nonroot, clk, rst, (state == S_DLEAF) |-> (node != '0), "leaf check on root")
endmodule
`default_nettype wire

>>> verif/huffman_tree_decoder_unit_tb.sv
// Self-checking testbench for the Huffman tree decoder unit: loads, decodes and table full.
`timescale 1ns / 1ps
module huffman_tree_decoder_unit_tb;

  localparam int NODES        = htd_pkg::NODES_DEF;
  localparam int MAX_LEN      = htd_pkg::MAX_CODE_LEN_DEF;
  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 150;
  localparam int CODE_COUNT   = 5;

  typedef struct packed {
    logic [7:0] symbol;
    logic [1:0] status;
    logic       last;
  } result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        command = htd_pkg::CMD_LOAD;
  logic [31:0] bits = '0;
  logic [5:0]  bit_count = '0;
  logic [7:0]  symbol_in = '0;
  logic        busy;
  logic        strobe;
  logic [7:0]  symbol_out;
  logic [1:0]  status;
  logic        last;

  int          shadow_left [NODES];
  int          shadow_right [NODES];
  logic [7:0]  shadow_byte [NODES];
  int          shadow_free;
  int          shadow_pos;
  int          shadow_full_count;

  result_t     owed_results [$];
  result_t     arrived;
  bit          stream_bits [$];

  int          idle_pct;
  int          errors;
  int          cycle_count;
  int          loads_sent;
  int          decodes_sent;
  int          results_seen;
  int          symbols_seen;
  int          bad_seen;
  int          full_seen;

  huffman_tree_decoder_unit #(
    .NODES(NODES),
    .MAX_CODE_LEN(MAX_LEN)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(command),
    .bits(bits),
    .bit_count(bit_count),
    .symbol_in(symbol_in),
    .strobe(strobe),
    .symbol_out(symbol_out),
    .status(status),
    .last(last)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic void pick_code(input int k, output logic [31:0] word, output int len,
                                    output logic [7:0] sym);
    case (k)
      0: begin word = 32'h0;  len = 1; sym = 8'h65; end
      1: begin word = 32'h2;  len = 2; sym = htd_pkg::CH_PERCENT; end
      2: begin word = 32'h6;  len = 3; sym = 8'h74; end
      3: begin word = 32'hE;  len = 4; sym = 8'hFF; end
      default: begin word = 32'h1E; len = 5; sym = 8'h00; end
    endcase
  endfunction

  task automatic walk_shadow_tree(input logic cmd, input logic [31:0] code,
                                  input logic [5:0] raw_count, input logic [7:0] sym);
    int         n;
    int         node;
    int         child;
    bit         b;
    bit         stopped;
    bit         emit;
    bit         have_held;
    logic [7:0] res_sym;
    logic [1:0] res_st;
    result_t    held;
    n = raw_count;
    if (n > 32) n = 32;
    if (n > MAX_LEN) n = MAX_LEN;
    stopped = 1'b0;
    have_held = 1'b0;
    if (cmd == htd_pkg::CMD_LOAD) begin
      node = 0;
      for (int j = 0; j < n && !stopped; j++) begin
        b = code[n-1-j];
        child = b ? shadow_right[node] : shadow_left[node];
        if (child == 0) begin
          if (shadow_free >= NODES) begin
            stopped = 1'b1;
          end else begin
            child = shadow_free;
            if (b) shadow_right[node] = child;
            else shadow_left[node] = child;
            shadow_byte[child] = sym;
            shadow_left[child] = 0;
            shadow_right[child] = 0;
            shadow_free++;
          end
        end
        node = child;
      end
      held.symbol = 8'h00;
      held.status = stopped ? htd_pkg::ST_FULL : htd_pkg::ST_LOADED;
      held.last = 1'b1;
      if (stopped) shadow_full_count++;
      owed_results.push_back(held);
    end else begin
      for (int j = 0; j < n; j++) begin
        b = code[n-1-j];
        child = b ? shadow_right[shadow_pos] : shadow_left[shadow_pos];
        emit = 1'b0;
        if (child == 0) begin
          emit = 1'b1;
          res_sym = 8'h00;
          res_st = htd_pkg::ST_BAD;
          shadow_pos = 0;
        end else if (shadow_left[child] == 0 && shadow_right[child] == 0) begin
          emit = 1'b1;
          res_sym = (shadow_byte[child] == htd_pkg::CH_PERCENT) ? htd_pkg::CH_NEWLINE
                                                                : shadow_byte[child];
          res_st = htd_pkg::ST_SYMBOL;
          shadow_pos = 0;
        end else begin
          shadow_pos = child;
        end
        if (emit) begin
          if (have_held) owed_results.push_back(held);
          held.symbol = res_sym;
          held.status = res_st;
          held.last = 1'b0;
          have_held = 1'b1;
        end
      end
      if (have_held) begin
        held.last = 1'b1;
        owed_results.push_back(held);
      end
    end
  endtask

  task automatic send_request(input logic cmd, input logic [31:0] code, input logic [5:0] cnt,
                              input logic [7:0] sym);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    command <= cmd;
    bits <= code;
    bit_count <= cnt;
    symbol_in <= sym;
    do @(negedge clk); while (busy !== 1'b0);
    @(posedge clk);
    walk_shadow_tree(cmd, code, cnt, sym);
    if (cmd == htd_pkg::CMD_LOAD) loads_sent++;
    else decodes_sent++;
  endtask

  task automatic hold_until_drained();
    start <= 1'b0;
    do @(posedge clk); while (owed_results.size() != 0);
  endtask

  task automatic send_stream_segment();
    int          n;
    int          k;
    int          len;
    logic [31:0] word;
    logic [31:0] seg;
    logic [7:0]  sym;
    n = $urandom_range(1, 32);
    while (stream_bits.size() < n) begin
      k = $urandom_range(0, CODE_COUNT - 1);
      pick_code(k, word, len, sym);
      for (int j = len - 1; j >= 0; j--) stream_bits.push_back(word[j]);
    end
    seg = $urandom;
    for (int j = n - 1; j >= 0; j--) seg[j] = stream_bits.pop_front();
    send_request(htd_pkg::CMD_DECODE, seg, 6'(n), 8'($urandom_range(255)));
  endtask

  task automatic send_side_branch_load();
    int          len;
    logic [31:0] word;
    len = $urandom_range(6, 32);
    word = $urandom | (32'h1F << (len - 5));
    send_request(htd_pkg::CMD_LOAD, word, 6'(len), 8'($urandom_range(255)));
  endtask

  task automatic test_empty_tree();
    idle_pct = 0;
    send_request(htd_pkg::CMD_DECODE, 32'hFFFF_FFFF, 6'd32, 8'h00);
    send_request(htd_pkg::CMD_DECODE, 32'h0000_0000, 6'd0, 8'hFF);
    send_request(htd_pkg::CMD_DECODE, 32'h1234_5678, 6'd63, 8'h00);
    send_request(htd_pkg::CMD_LOAD, 32'hFFFF_FFFF, 6'd0, 8'hAA);
  endtask

  task automatic test_code_loading();
    logic [31:0] word;
    int          len;
    logic [7:0]  sym;
    idle_pct = 0;
    for (int k = 0; k < CODE_COUNT; k++) begin
      pick_code(k, word, len, sym);
      send_request(htd_pkg::CMD_LOAD, word, 6'(len), sym);
    end
    send_request(htd_pkg::CMD_LOAD, 32'h6, 6'd3, 8'h41);
    send_request(htd_pkg::CMD_LOAD, 32'h3, 6'd2, 8'h42);
    send_request(htd_pkg::CMD_LOAD, 32'hFFFF_FFFF, 6'd40, 8'h5A);
  endtask

  task automatic test_segment_decoding();
    idle_pct = 0;
    send_request(htd_pkg::CMD_DECODE, 32'h0, 6'd1, 8'h00);
    send_request(htd_pkg::CMD_DECODE, 32'h2, 6'd2, 8'h00);
    send_request(htd_pkg::CMD_DECODE, 32'h3, 6'd2, 8'h00);
    send_request(htd_pkg::CMD_DECODE, 32'h0, 6'd1, 8'h00);
    send_request(htd_pkg::CMD_DECODE, 32'h7, 6'd3, 8'h00);
    hold_until_drained();
    send_request(htd_pkg::CMD_LOAD, 32'h6, 6'd3, 8'h33);
    send_request(htd_pkg::CMD_DECODE, 32'h0, 6'd1, 8'h00);
    send_request(htd_pkg::CMD_DECODE, 32'h1E, 6'd5, 8'h00);
    send_request(htd_pkg::CMD_DECODE, 32'h3E, 6'd6, 8'h00);
    send_request(htd_pkg::CMD_DECODE, 32'h0000_0000, 6'd32, 8'h00);
    send_request(htd_pkg::CMD_DECODE, 32'hAAAA_AAAA, 6'd32, 8'h00);
    send_request(htd_pkg::CMD_DECODE, 32'hFFFF_FFFF, 6'd32, 8'h00);
  endtask

  task automatic test_random_traffic(input int pct, input int count);
    int r;
    int cnt;
    idle_pct = pct;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 72) begin
        send_stream_segment();
      end else if (r < 84) begin
        cnt = ($urandom_range(19) == 0) ? $urandom_range(63) : $urandom_range(1, 32);
        send_request(htd_pkg::CMD_DECODE, $urandom, 6'(cnt), 8'($urandom_range(255)));
      end else if (r < 96) begin
        send_side_branch_load();
      end else begin
        hold_until_drained();
        send_stream_segment();
      end
    end
  endtask

  task automatic test_table_full();
    int tries;
    idle_pct = 30;
    tries = 0;
    while (shadow_full_count < 3 && tries < 60) begin
      send_request(htd_pkg::CMD_LOAD, $urandom, 6'd32, 8'($urandom_range(255)));
      tries++;
    end
    send_request(htd_pkg::CMD_LOAD, 32'h0, 6'd1, 8'h99);
    send_request(htd_pkg::CMD_DECODE, $urandom, 6'd32, 8'h00);
    for (int i = 0; i < 4; i++) send_stream_segment();
  endtask

  always @(negedge clk) begin
    if (!rst && strobe === 1'b1) begin
      results_seen++;
      if (status === htd_pkg::ST_SYMBOL) symbols_seen++;
      if (status === htd_pkg::ST_BAD) bad_seen++;
      if (status === htd_pkg::ST_FULL) full_seen++;
      if (owed_results.size() == 0) begin
        $error("unrequested result: symbol_out %0h status %0d last %0b",
               symbol_out, status, last);
        errors++;
      end else begin
        arrived = owed_results.pop_front();
        if (symbol_out !== arrived.symbol) begin
          $error("symbol_out: expected %0h, actual %0h", arrived.symbol, symbol_out);
          errors++;
        end
        if (status !== arrived.status) begin
          $error("status: expected %0d, actual %0d", arrived.status, status);
          errors++;
        end
        if (last !== arrived.last) begin
          $error("last: expected %0b, actual %0b", arrived.last, last);
          errors++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < NODES; i++) begin
      shadow_left[i] = 0;
      shadow_right[i] = 0;
      shadow_byte[i] = 8'h00;
    end
    shadow_free = 1;
    shadow_pos = 0;
    shadow_full_count = 0;
    idle_pct = 0;
    errors = 0;
    cycle_count = 0;
    loads_sent = 0;
    decodes_sent = 0;
    results_seen = 0;
    symbols_seen = 0;
    bad_seen = 0;
    full_seen = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_tree();
    test_code_loading();
    test_segment_decoding();
    test_random_traffic(0, 22);
    test_random_traffic(74, 22);
    test_random_traffic(30, 22);
    test_table_full();

    start <= 1'b0;
    @(posedge clk);
    while (owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests: %0d loads and %0d decode segments; checked %0d results.",
             loads_sent + decodes_sent, loads_sent, decodes_sent, results_seen);
    $display("Saw %0d symbols, %0d bad codes and %0d table-full reports; %0d errors.",
             symbols_seen, bad_seen, full_seen, errors);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
